/* design/sha1md_pkg.sv */
// Package for the SHA-1 message digest block: constants, command and status types.
// No dependencies; used by the datapath, the controller and the top level.
package sha1md_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NUM_H    = 5;
  localparam int unsigned WIN_D    = 16;
  localparam int unsigned ROUNDS   = 80;
  localparam logic [2:0]  LAST_IDX = 3'd4;

  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hEFCD_AB89;
  localparam logic [31:0] IV2 = 32'h98BA_DCFE;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // Round groups of twenty
  localparam logic [1:0] PH_CH   = 2'd0;
  localparam logic [1:0] PH_PAR1 = 2'd1;
  localparam logic [1:0] PH_MAJ  = 2'd2;
  localparam logic [1:0] PH_PAR2 = 2'd3;

  // Kinds of padding word written into the window
  localparam logic [1:0] PAD_MARK  = 2'd0;
  localparam logic [1:0] PAD_ZERO  = 2'd1;
  localparam logic [1:0] PAD_LENHI = 2'd2;
  localparam logic [1:0] PAD_LENLO = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic       absorb;    // take the input transaction into the byte packer
    logic       pad_wr;    // write one padding word
    logic [1:0] pad_kind;
    logic       ld_work;   // working variables <= chaining values
    logic       round;     // one compression round
    logic [1:0] phase;
    logic       fold;      // chaining values += working variables
    logic       emit;      // load one digest word into the output register
    logic [2:0] idx;
    logic       clear;     // back to the initial state for the next message
  } cmd_t;

  typedef struct packed {
    logic absorb_full;     // this absorb completes the sixteenth word
    logic fill_last;       // fifteen words held
    logic fill_14;         // fourteen words held
    logic out_free;        // output register can take a word this cycle
  } sts_t;

  function automatic word_t k_of(input logic [1:0] ph);
    word_t k;
    unique case (ph)
      PH_CH:   k = 32'h5A82_7999;
      PH_PAR1: k = 32'h6ED9_EBA1;
      PH_MAJ:  k = 32'h8F1B_BCDC;
      PH_PAR2: k = 32'hCA62_C1D6;
      default: k = 32'h5A82_7999;
    endcase
    return k;
  endfunction

  function automatic word_t iv_of(input logic [2:0] i);
    word_t v;
    unique case (i)
      3'd0:    v = IV0;
      3'd1:    v = IV1;
      3'd2:    v = IV2;
      3'd3:    v = IV3;
      default: v = IV4;
    endcase
    return v;
  endfunction

endpackage

/* design/sha1md_if.sv */
// Valid/ready channel interfaces for the SHA-1 message digest block.
// Depends on nothing; used by sha1_message_digest_top.
interface sha1md_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, msg_word, byte_count, last, input ready);
  modport sink   (input valid, msg_word, byte_count, last, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_done;

  modport source (output valid, digest_word, word_index, digest_done, input ready);
  modport sink   (input valid, digest_word, word_index, digest_done, output ready);
endinterface

/* design/sha1md_datapath.sv */
// SHA-1 datapath: byte packer, 16-word schedule shift line, round logic,
// chaining values, length counter and output register. Uses sha1md_pkg.
module sha1md_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1md_pkg::cmd_t    cmd,
  output sha1md_pkg::sts_t    sts,
  input  logic [31:0]         msg_word,
  input  logic [2:0]          byte_count,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                digest_done
);

  sha1md_pkg::word_t chain_r [sha1md_pkg::NUM_H];
  sha1md_pkg::word_t work_r  [sha1md_pkg::NUM_H];
  sha1md_pkg::word_t win_r   [sha1md_pkg::WIN_D];
  logic [3:0]        fill_r;
  logic [23:0]       part_r;      // left-aligned pending bytes, unused bytes zero
  logic [1:0]        part_cnt_r;
  logic [63:0]       bit_len_r;
  logic              out_valid_r;
  logic [31:0]       digest_r;
  logic [2:0]        index_r;
  logic              done_r;

  logic [2:0]        cnt;
  logic [31:0]       mask;
  logic [55:0]       cat;
  logic [2:0]        total;
  logic              has_word;
  logic [31:0]       pad_mark;
  logic [31:0]       sched_new;
  logic [31:0]       wdata;
  logic              shift_en;
  logic [31:0]       f_val;
  logic [31:0]       t_val;
  logic [31:0]       sel_chain;

  // Byte packer
  assign cnt      = (byte_count > 3'd4) ? 3'd4 : byte_count;
  assign mask     = ~(32'hFFFF_FFFF >> {cnt, 3'b000});
  assign cat      = {part_r, 32'h0} | ({msg_word & mask, 24'h0} >> {part_cnt_r, 3'b000});
  assign total    = {1'b0, part_cnt_r} + cnt;
  assign has_word = total[2];
  assign pad_mark = {part_r, 8'h00} | ({sha1md_pkg::PAD_BYTE, 24'h0} >> {part_cnt_r, 3'b000});

  assign sched_new = {win_r[13][30:0] ^ win_r[8][30:0] ^ win_r[2][30:0] ^ win_r[0][30:0],
                      win_r[13][31] ^ win_r[8][31] ^ win_r[2][31] ^ win_r[0][31]};

  always_comb begin
    wdata = cat[55:24];
    if (cmd.round) begin
      wdata = sched_new;
    end else if (cmd.pad_wr) begin
      unique case (cmd.pad_kind)
        sha1md_pkg::PAD_MARK:  wdata = pad_mark;
        sha1md_pkg::PAD_ZERO:  wdata = '0;
        sha1md_pkg::PAD_LENHI: wdata = bit_len_r[63:32];
        sha1md_pkg::PAD_LENLO: wdata = bit_len_r[31:0];
        default:               wdata = '0;
      endcase
    end
  end

  assign shift_en = cmd.round || cmd.pad_wr || (cmd.absorb && has_word);

  // Round function
  always_comb begin
    unique case (cmd.phase)
      sha1md_pkg::PH_CH:  f_val = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
      sha1md_pkg::PH_MAJ: f_val = (work_r[1] & work_r[2]) | (work_r[1] & work_r[3])
                                | (work_r[2] & work_r[3]);
      default:            f_val = work_r[1] ^ work_r[2] ^ work_r[3];
    endcase
  end

  assign t_val = {work_r[0][26:0], work_r[0][31:27]} + f_val + work_r[4]
               + sha1md_pkg::k_of(cmd.phase) + win_r[0];

  always_comb begin
    unique case (cmd.idx)
      3'd0:    sel_chain = chain_r[0];
      3'd1:    sel_chain = chain_r[1];
      3'd2:    sel_chain = chain_r[2];
      3'd3:    sel_chain = chain_r[3];
      default: sel_chain = chain_r[4];
    endcase
  end

  // Schedule window: taps of a shift line, oldest word at entry 0
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < sha1md_pkg::WIN_D - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sha1md_pkg::WIN_D-1] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      part_r      <= '0;
      part_cnt_r  <= '0;
      bit_len_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < sha1md_pkg::NUM_H; i++) begin
        chain_r[i] <= sha1md_pkg::iv_of(3'(i));
        work_r[i]  <= '0;
      end
    end else begin
      if (cmd.clear) begin
        fill_r     <= '0;
        part_r     <= '0;
        part_cnt_r <= '0;
        bit_len_r  <= '0;
      end else begin
        if (shift_en && !cmd.round) begin
          fill_r <= fill_r + 4'd1;
        end
        if (cmd.absorb) begin
          part_r     <= has_word ? cat[23:0] : cat[55:32];
          part_cnt_r <= total[1:0];
          bit_len_r  <= bit_len_r + {58'h0, cnt, 3'b000};
        end else if (cmd.pad_wr && cmd.pad_kind == sha1md_pkg::PAD_MARK) begin
          part_r     <= '0;
          part_cnt_r <= '0;
        end
      end

      if (cmd.ld_work) begin
        for (int i = 0; i < sha1md_pkg::NUM_H; i++) begin
          work_r[i] <= chain_r[i];
        end
      end else if (cmd.round) begin
        work_r[0] <= t_val;
        work_r[1] <= work_r[0];
        work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
        work_r[3] <= work_r[2];
        work_r[4] <= work_r[3];
      end

      if (cmd.clear) begin
        for (int i = 0; i < sha1md_pkg::NUM_H; i++) begin
          chain_r[i] <= sha1md_pkg::iv_of(3'(i));
        end
      end else if (cmd.fold) begin
        for (int i = 0; i < sha1md_pkg::NUM_H; i++) begin
          chain_r[i] <= chain_r[i] + work_r[i];
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digest_r <= sel_chain;
      index_r  <= cmd.idx;
      done_r   <= (cmd.idx == sha1md_pkg::LAST_IDX);
    end
  end

  assign sts.absorb_full = has_word && (fill_r == 4'd15);
  assign sts.fill_last   = (fill_r == 4'd15);
  assign sts.fill_14     = (fill_r == 4'd14);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign digest_word = digest_r;
  assign word_index  = index_r;
  assign digest_done = done_r;

endmodule

/* design/sha1md_ctrl.sv */
// SHA-1 controller: state machine sequencing absorb, compression rounds,
// padding and digest output. Uses sha1md_pkg; drives sha1md_datapath.
module sha1md_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  sha1md_pkg::sts_t sts,
  output sha1md_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [1:0] ST_MARK  = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_LENLO = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [6:0] LAST_ROUND = 7'(sha1md_pkg::ROUNDS - 1);

  logic [2:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       ending_r, ending_nxt;
  logic [6:0] round_r, round_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    ending_nxt = ending_r;
    round_nxt  = round_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    cmd.idx    = idx_r;
    in_ready   = 1'b0;

    priority if (round_r < 7'd20) begin
      cmd.phase = sha1md_pkg::PH_CH;
    end else if (round_r < 7'd40) begin
      cmd.phase = sha1md_pkg::PH_PAR1;
    end else if (round_r < 7'd60) begin
      cmd.phase = sha1md_pkg::PH_MAJ;
    end else begin
      cmd.phase = sha1md_pkg::PH_PAR2;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.absorb = 1'b1;
          if (in_last) begin
            ending_nxt = 1'b1;
            step_nxt   = ST_MARK;
          end
          if (sts.absorb_full) begin
            state_nxt = S_LOAD;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_LOAD: begin
        cmd.ld_work = 1'b1;
        round_nxt   = '0;
        state_nxt   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (round_r == LAST_ROUND) begin
          round_nxt = '0;
          state_nxt = S_FOLD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (!ending_r) begin
          state_nxt = S_IDLE;
        end else if (step_r == ST_DONE) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        unique case (step_r)
          ST_MARK: begin
            cmd.pad_wr   = 1'b1;
            cmd.pad_kind = sha1md_pkg::PAD_MARK;
            step_nxt     = ST_ZERO;
            if (sts.fill_last) begin
              state_nxt = S_LOAD;
            end
          end
          ST_ZERO: begin
            cmd.pad_wr = 1'b1;
            if (sts.fill_14) begin
              cmd.pad_kind = sha1md_pkg::PAD_LENHI;
              step_nxt     = ST_LENLO;
            end else begin
              cmd.pad_kind = sha1md_pkg::PAD_ZERO;
              if (sts.fill_last) begin
                state_nxt = S_LOAD;
              end
            end
          end
          ST_LENLO: begin
            cmd.pad_wr   = 1'b1;
            cmd.pad_kind = sha1md_pkg::PAD_LENLO;
            step_nxt     = ST_DONE;
            state_nxt    = S_LOAD;
          end
          ST_DONE: begin
            idx_nxt   = '0;
            state_nxt = S_EMIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (idx_r == sha1md_pkg::LAST_IDX) begin
            cmd.clear  = 1'b1;
            ending_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= ST_MARK;
      ending_r <= 1'b0;
      round_r  <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      ending_r <= ending_nxt;
      round_r  <= round_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

/* design/sha1_message_digest_top.sv */
// SHA-1 message digest, top level. Depends on sha1md_pkg, sha1md_if,
// sha1md_datapath and sha1md_ctrl.
//
// Feed the message as big-endian 32-bit words on in_ch, each with a count of valid
// bytes (values above four count as four) and a last flag; short words may appear
// anywhere and later bytes follow on directly. An empty message is a single last
// transaction with zero bytes. On the last word the block pads the message, adds
// the 64-bit bit length (wrapping at 2^64) and returns five transactions on out_ch,
// h0 first, digest_done set on h4, then starts afresh from the initial hash values.
// Timing: one input word per cycle while input is open; each completed 64-byte block
// holds off input for a load step, 80 rounds of the single shared round unit and a
// fold step. Finalisation writes the padding words, runs one or two compressions,
// then loads the digest words one by one, waiting whenever out_ch stalls. One message
// is processed at a time; input is refused from the last word until the final digest
// word has been loaded into the output register.
module sha1_message_digest_top (
  input  logic        clk,
  input  logic        rst_n,
  sha1md_in_if.sink   in_ch,
  sha1md_out_if.source out_ch
);

  sha1md_pkg::cmd_t cmd;
  sha1md_pkg::sts_t sts;

  // Sequencer: accepts input, steps rounds and padding, drives output loads
  sha1md_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Packer, schedule window, round unit, chaining values and output register
  sha1md_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .msg_word    (in_ch.msg_word),
    .byte_count  (in_ch.byte_count),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .digest_word (out_ch.digest_word),
    .word_index  (out_ch.word_index),
    .digest_done (out_ch.digest_done)
  );

`ifndef NO_ASSERTIONS
  // A last word always starts finalisation, so input closes next cycle
  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.last |=> !in_ch.ready)
    else $error("input open after last word");

  // While a digest is only partly delivered, no new message may enter
  a_no_input_mid_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.digest_done |-> !in_ch.ready)
    else $error("input open during digest output");

  // Nothing follows the final digest word once it has been taken
  a_done_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.digest_done |=> !out_ch.valid)
    else $error("output after final digest word");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for sha1_message_digest_top: random and directed messages,
// digest words predicted by an internal SHA-1 tracker.
// Depends on sha1md_pkg, sha1md_if and the design files under design/.

// Tracks the message stream and holds the digest words still due from the block.
class digest_tracker;
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        done;
  } digest_word_t;

  logic [31:0]  chain[5];
  logic [31:0]  window[16];
  int unsigned  fill;
  int unsigned  part_n;
  logic [31:0]  part;
  logic [63:0]  bits_seen;
  digest_word_t due[$];
  int unsigned  errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0]  = sha1md_pkg::IV0;
    chain[1]  = sha1md_pkg::IV1;
    chain[2]  = sha1md_pkg::IV2;
    chain[3]  = sha1md_pkg::IV3;
    chain[4]  = sha1md_pkg::IV4;
    fill      = 0;
    part_n    = 0;
    part      = '0;
    bits_seen = '0;
  endfunction

  function logic [31:0] rotl(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // 80 rounds over the sixteen held words, schedule expanded in place
  function void compress();
    logic [31:0] a, b, c, d, e, f, k, t;
    int unsigned slot;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      slot = r % 16;
      if (r >= 16)
        window[slot] = rotl(window[(slot + 13) % 16] ^ window[(slot + 8) % 16]
                            ^ window[(slot + 2) % 16] ^ window[slot], 1);
      case (r / 20)
        0: begin
          f = (b & c) | (~b & d);
          k = 32'h5A82_7999;
        end
        1: begin
          f = b ^ c ^ d;
          k = 32'h6ED9_EBA1;
        end
        2: begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1B_BCDC;
        end
        default: begin
          f = b ^ c ^ d;
          k = 32'hCA62_C1D6;
        end
      endcase
      t = rotl(a, 5) + f + e + k + window[slot];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  function void put_byte(logic [7:0] v);
    part = {part[23:0], v};
    part_n++;
    if (part_n == 4) begin
      window[fill] = part;
      part   = '0;
      part_n = 0;
      fill++;
      if (fill == 16) begin
        fill = 0;
        compress();
      end
    end
  endfunction

  // One accepted input transaction
  function void absorb_word(logic [31:0] w, logic [2:0] cnt, logic lst);
    int unsigned  n;
    logic [63:0]  len;
    digest_word_t dw;
    n = (cnt > 3'd4) ? 4 : cnt;
    for (int i = 0; i < n; i++) begin
      put_byte(w[31 - 8 * i -: 8]);
      bits_seen += 64'd8;
    end
    if (!lst)
      return;
    len = bits_seen;
    put_byte(sha1md_pkg::PAD_BYTE);
    while (fill * 4 + part_n != 56)
      put_byte(8'h00);
    for (int i = 0; i < 8; i++)
      put_byte(len[63 - 8 * i -: 8]);
    for (int i = 0; i < 5; i++) begin
      dw.word  = chain[i];
      dw.index = i[2:0];
      dw.done  = (i == 4);
      due.insert(due.size(), dw);
    end
    restart();
  endfunction

  // One accepted output transaction
  function void match_digest_word(logic [31:0] w, logic [2:0] idx, logic done);
    digest_word_t dw;
    if (due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected digest word %h idx %0d done %b", w, idx, done);
      return;
    end
    dw = due.pop_front();
    if (dw.word !== w || dw.index !== idx || dw.done !== done) begin
      errors++;
      if (errors <= 10)
        $display("digest mismatch: exp %h idx %0d done %b, got %h idx %0d done %b",
                 dw.word, dw.index, dw.done, w, idx, done);
    end
  endfunction

  function int unsigned pending();
    return due.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n;

  sha1md_in_if  in_ch();
  sha1md_out_if out_ch();

  sha1_message_digest_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digest_tracker tracker;

  // Idling odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent     = 0;
  int unsigned cycle_count    = 0;

  always #10 clk = ~clk;

  // Watchdog: a stuck handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: ready redrawn every falling edge, so stalls land on any phase
  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Result monitor: sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.match_digest_word(out_ch.digest_word, out_ch.word_index, out_ch.digest_done);
  end

  // Drive one word and hold it until the block takes it. valid is left high
  // afterwards, so back-to-back transactions never drop it within a step.
  // Idle cycles are drawn one by one at the sender's odds.
  task automatic send_word(logic [31:0] w, logic [2:0] cnt, logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.msg_word   <= w;
    in_ch.byte_count <= cnt;
    in_ch.last       <= lst;
    do @(posedge clk); while (!in_ch.ready);
    tracker.absorb_word(w, cnt, lst);
    words_sent++;
  endtask

  // Sender goes quiet until every digest word due has been taken
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0)
      @(posedge clk);
  endtask

  // Mostly full words; the odd short, empty or over-counted word mid-message,
  // and any byte count on the last word. Lengths cross the 55/56/64-byte edges.
  task automatic send_random_message();
    int unsigned nwords;
    int unsigned pick;
    logic [2:0]  cnt;
    nwords = ($urandom_range(7) == 0) ? $urandom_range(21, 40) : $urandom_range(0, 20);
    for (int k = 0; k < nwords; k++) begin
      pick = $urandom_range(99);
      if (pick < 8)
        cnt = $urandom_range(0, 3);
      else if (pick < 11)
        cnt = $urandom_range(5, 7);
      else
        cnt = 3'd4;
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, $urandom_range(0, 7), 1'b1);
  endtask

  initial begin
    int unsigned target;
    tracker          = new();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.msg_word   = '0;
    in_ch.byte_count = '0;
    in_ch.last       = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, with ignored payload bits set
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    // "abc" in one short last word
    send_word(32'h6162_6300, 3'd3, 1'b1);
    // over-range count on a last word counts as four bytes
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    // short and empty words mid-message; bytes pack straight on
    send_word(32'h0000_0000, 3'd1, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_word(32'hA5A5_A5A5, 3'd2, 1'b0);
    send_word(32'h1234_5678, 3'd5, 1'b0);
    send_word(32'h5A5A_5A5A, 3'd6, 1'b1);
    // 55 bytes: pad and length just fit in one block
    for (int k = 0; k < 13; k++)
      send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    // Each phase ends with the sender paused until the block has emptied.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      target = words_sent + 66;
      while (words_sent < target)
        send_random_message();
      drain();
    end

    // Let any stray late transaction show up before the verdict
    repeat (300) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
